/* hdl/base32_byte_encoder_macros.svh */
// ----------------------------------------------------------------------------
// Base32 byte encoder assertion macros
// Concurrent assertion wrappers shared by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE32_BYTE_ENCODER_MACROS_SVH
`define BASE32_BYTE_ENCODER_MACROS_SVH

// same-cycle implication
`define B32E_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define B32E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/b32e_pkg.sv */
// ----------------------------------------------------------------------------
// Base32 byte encoder package
// Shared types, constants and the character table of the encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

   localparam int GROUP_W    = 5;
   localparam int CHAR_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int MAX_GROUPS = 3;
   localparam int COUNT_W    = 2;
   localparam int POS_W      = 3;
   localparam int IDX_W      = 2;

   localparam logic [POS_W-1:0] POS_0     = 3'd0;
   localparam logic [POS_W-1:0] POS_1     = 3'd1;
   localparam logic [POS_W-1:0] POS_2     = 3'd2;
   localparam logic [POS_W-1:0] POS_3     = 3'd3;
   localparam logic [POS_W-1:0] POS_4     = 3'd4;
   localparam logic [POS_W-1:0] POS_COUNT = 3'd5;

   typedef logic [GROUP_W-1:0] group_type;
   typedef logic [CHAR_W-1:0]  char_type;

   typedef struct packed {
      group_type [MAX_GROUPS-1:0] groups;
      logic [COUNT_W-1:0]         count;
      logic                       last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam char_type ALPHABET [32] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h46, 7'h47,
      7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h50, 7'h51,
      7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
   };

   function automatic char_type char_of(group_type g);
      return ALPHABET[g];
   endfunction

endpackage

/* hdl/b32e_front.sv */
// ----------------------------------------------------------------------------
// Base32 encoder front end
// Accepts bytes, tracks position and held byte, splits each byte into groups.
// ----------------------------------------------------------------------------
module b32e_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] data_byte
   input  logic                         req_tlast,   // end_of_message
   input  b32e_pkg::queue_status_type   q_status,
   output logic                         push,
   output b32e_pkg::entry_type          push_entry,
   output logic [b32e_pkg::POS_W-1:0]   position
);
   import b32e_pkg::*;

   logic [BYTE_W-1:0] held_ff, held_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] p, c;
   group_type         g0, g1, g2;
   logic [COUNT_W-1:0] base_n;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;
   assign position   = pos_ff;
   assign p          = held_ff;
   assign c          = req_tdata;
   assign pos        = (pos_ff >= POS_COUNT) ? POS_W'(pos_ff - POS_COUNT) : pos_ff;

   always_comb begin
      g0     = '0;
      g1     = '0;
      g2     = '0;
      base_n = 2'd2;
      unique case (pos)
         POS_0: begin
            g0     = c[7:3];
            g1     = {c[2:0], 2'b00};
            base_n = 2'd1;
         end
         POS_1: begin
            g0 = {p[2:0], c[7:6]};
            g1 = c[5:1];
            g2 = {c[0], 4'b0000};
         end
         POS_2: begin
            g0     = {p[0], c[7:4]};
            g1     = {c[3:0], 1'b0};
            base_n = 2'd1;
         end
         POS_3: begin
            g0 = {p[3:0], c[7]};
            g1 = c[6:2];
            g2 = {c[1:0], 3'b000};
         end
         default: begin
            g0 = {p[1:0], c[7:5]};
            g1 = c[4:0];
         end
      endcase
   end

   always_comb begin
      push_entry.groups = {g2, g1, g0};
      push_entry.last   = req_tlast;
      push_entry.count  = (req_tlast && pos != POS_4) ? COUNT_W'(base_n + 2'd1) : base_n;
   end

   always_comb begin
      held_in = held_ff;
      pos_in  = pos_ff;
      if (push) begin
         if (req_tlast) begin
            held_in = '0;
            pos_in  = POS_0;
         end else begin
            held_in = c;
            pos_in  = (pos == POS_4) ? POS_0 : POS_W'(pos + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pos_ff  <= POS_0;
      end else begin
         held_ff <= held_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

/* hdl/b32e_queue.sv */
// ----------------------------------------------------------------------------
// Base32 encoder queue
// Short first-in first-out buffer of group entries between front and back.
// ----------------------------------------------------------------------------
module b32e_queue #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  b32e_pkg::entry_type         push_entry,
   input  logic                        pop,
   output b32e_pkg::entry_type         pop_entry,
   output b32e_pkg::queue_status_type  status
);
   import b32e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign pop_entry    = slot_ff[rd_ff];
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ff + 1'b1);
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ff + 1'b1);
      unique case ({push, pop})
         2'b10:   cnt_in = CNT_W'(cnt_ff + 1'b1);
         2'b01:   cnt_in = CNT_W'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/b32e_back.sv */
// ----------------------------------------------------------------------------
// Base32 encoder back end
// Walks the groups of each entry and drives one character per cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
module b32e_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b32e_pkg::queue_status_type  q_status,
   output logic                        pop,
   input  b32e_pkg::entry_type         pop_entry,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [6:0] char_code, [7] zero
   output logic                        rsp_tlast    // last_char
);
   import b32e_pkg::*;

   entry_type        cur_ff, cur_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   char_type         out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;
   logic             out_load;
   logic             fin;

   assign out_load = !out_valid_ff || rsp_tready;
   assign fin      = busy_ff && out_load && (idx_ff == IDX_W'(cur_ff.count - 2'd1));
   assign pop      = !q_status.empty && (!busy_ff || fin);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (busy_ff && out_load) begin
         out_valid_in = 1'b1;
         out_char_in  = char_of(cur_ff.groups[idx_ff]);
         out_last_in  = cur_ff.last && fin;
         idx_in       = IDX_W'(idx_ff + 1'b1);
         if (fin) busy_in = 1'b0;
      end
      if (pop) begin
         cur_in  = pop_entry;
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* hdl/base32_byte_encoder.sv */
// A byte's groups go through the entry queue and the back end's entry register to the output register.
// Throughput: one character per cycle at the output register while rsp_tready
// is high; a byte yields 1 or 2 characters (up to 3 on a final byte).
// The entry queue (QUEUE_DEPTH entries) lets the input run ahead of the output.
// Reset: synchronous; clears position, held byte, queue and output valid.
// ----------------------------------------------------------------------------
// Base32 byte encoder
// Streams message bytes in and base32 characters out, no padding characters.
// ----------------------------------------------------------------------------
`include "base32_byte_encoder_macros.svh"

module base32_byte_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] char_code, [7] zero
   output logic       rsp_tlast     // last_char
);
   import b32e_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        pop_entry;
   logic             push;
   logic             pop;
   logic [POS_W-1:0] position;

   b32e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry),
      .position   (position)
   );

   b32e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   b32e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `B32E_ASSERT_SAME(a_no_push_when_full, clock, reset, q_status.full, !req_tready && !push, "item taken while queue full")
   `B32E_ASSERT_SAME(a_no_pop_when_empty, clock, reset, q_status.empty, !pop, "queue popped while empty")
   `B32E_ASSERT_NEXT(a_position_restart, clock, reset, push && req_tlast, position == POS_0, "position not cleared after final byte")
   `B32E_ASSERT_SAME(a_char_range, clock, reset, rsp_tvalid, rsp_tdata[7] == 1'b0 && rsp_tdata >= 8'h30 && rsp_tdata <= 8'h5A, "character outside alphabet range")

endmodule

/* bench/b32e_stream_checker.sv */
// ----------------------------------------------------------------------------
// Base32 encoder stream checker
// Watches the byte and character channels of the encoder. For every byte it
// accepts it works out the characters due from its own copy of the encoder
// state, queues them, and compares each character that leaves the block with
// the oldest one queued.
// ----------------------------------------------------------------------------
module b32e_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // end_of_message
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [6:0] char_code, [7] zero
   input  logic       rsp_tlast,    // last_char
   output int         fail_count,
   output int         chars_pending
);
   import b32e_pkg::*;

   localparam bit [8*32-1:0] CHARSET = "0123456789ABCDFGHJKLMNPQRSTVWXYZ";

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_item_type;

   char_item_type     pending_chars[$];
   logic [BYTE_W-1:0] prev_byte;
   logic [POS_W-1:0]  byte_pos;

   function automatic logic [CHAR_W-1:0] letter(input logic [GROUP_W-1:0] g);
      logic [7:0] ascii;
      ascii = CHARSET[8*(31-g) +: 8];
      return ascii[CHAR_W-1:0];
   endfunction

   task automatic encode_byte(input logic [BYTE_W-1:0] c, input logic eom);
      logic [GROUP_W-1:0] groups[MAX_GROUPS];
      logic [GROUP_W-1:0] tail;
      logic [POS_W-1:0]   pos;
      logic [BYTE_W-1:0]  p;
      char_item_type      item;
      int                 n;
      p    = prev_byte;
      pos  = byte_pos % POS_COUNT;
      tail = '0;
      n    = 1;
      case (pos)
         POS_0: begin
            groups[0] = c[7:3];
            tail      = {c[2:0], 2'b00};
         end
         POS_1: begin
            groups[0] = {p[2:0], c[7:6]};
            groups[1] = c[5:1];
            tail      = {c[0], 4'b0000};
            n         = 2;
         end
         POS_2: begin
            groups[0] = {p[0], c[7:4]};
            tail      = {c[3:0], 1'b0};
         end
         POS_3: begin
            groups[0] = {p[3:0], c[7]};
            groups[1] = c[6:2];
            tail      = {c[1:0], 3'b000};
            n         = 2;
         end
         default: begin
            groups[0] = {p[1:0], c[7:5]};
            groups[1] = c[4:0];
            n         = 2;
         end
      endcase
      if (eom && pos != POS_4) begin
         groups[n] = tail;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         item.code = letter(groups[k]);
         item.last = eom && (k == n - 1);
         pending_chars.push_back(item);
      end
      if (eom) begin
         prev_byte = '0;
         byte_pos  = POS_0;
      end else begin
         prev_byte = c;
         byte_pos  = (pos + 1'b1) % POS_COUNT;
      end
   endtask

   task automatic check_char();
      char_item_type want;
      if (pending_chars.size() == 0) begin
         $error("unexpected character: char_code %0h last_char %0b",
                rsp_tdata[6:0], rsp_tlast);
         fail_count++;
      end else begin
         want = pending_chars.pop_front();
         if (rsp_tdata[6:0] !== want.code) begin
            $error("char_code: expected %0h actual %0h", want.code, rsp_tdata[6:0]);
            fail_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last_char: expected %0b actual %0b", want.last, rsp_tlast);
            fail_count++;
         end
         if (rsp_tdata[7] !== 1'b0) begin
            $error("tdata pad bit: expected 0 actual %0b", rsp_tdata[7]);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count    = 0;
      chars_pending = 0;
      prev_byte     = '0;
      byte_pos      = POS_0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pending_chars.delete();
         prev_byte = '0;
         byte_pos  = POS_0;
      end else begin
         if (req_tvalid && req_tready)
            encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_char();
      end
      chars_pending <= pending_chars.size();
   end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Base32 byte encoder testbench
// Feeds whole messages into the encoder: a directed set that ends a message
// on every byte position with all-ones bytes, two all-zeros messages, then
// random messages of mixed length under three idling regimes, one with a
// long output stall that backs the block up. A checker module predicts and
// compares the characters; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_OFF     = 80;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 16;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int fail_count;
   int chars_pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int cycles        = 0;
   bit hold_off_due  = 1'b0;

   always #4 clock = ~clock;

   base32_byte_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   b32e_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .chars_pending (chars_pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // hold the output off for a long stretch when asked, else idle at random
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            repeat (HOLD_OFF) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // fill: 0 all ones, 1 all zeros, otherwise random bytes
   task automatic send_message(input int len, input int fill);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (fill)
            0:       b = 8'hFF;
            1:       b = 8'h00;
            default: b = 8'($urandom_range(255));
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic random_phase(input int sender_pct, input int receiver_pct);
      int stop_at;
      int len;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      stop_at       = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < stop_at) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         send_message(len, 2);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 79;
      for (int len = 1; len <= 5; len++)
         send_message(len, 0);
      send_message(1, 1);
      send_message(6, 1);

      random_phase(20, 79);
      random_phase(79, 20);
      hold_off_due = 1'b1;
      random_phase(0, 0);

      req_tvalid <= 1'b0;
      while (chars_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && chars_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* base32_byte_encoder.f */
+incdir+hdl
hdl/b32e_pkg.sv
hdl/b32e_front.sv
hdl/b32e_queue.sv
hdl/b32e_back.sv
hdl/base32_byte_encoder.sv
bench/b32e_stream_checker.sv
bench/tb.sv
